/* rtl/ipv6_neighbor_cache_assert.svh */
// Assertion macros for the IPv6 neighbor cache.
`ifndef IPV6_NEIGHBOR_CACHE_ASSERT_SVH
`define IPV6_NEIGHBOR_CACHE_ASSERT_SVH

// check a condition at every edge outside reset
`define IPNC_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// check a consequence in the same cycle
`define IPNC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check a consequence in the next cycle
`define IPNC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ipnc_pkg.sv */
// Types and constants shared by the IPv6 neighbor cache.
`default_nettype none

package ipnc_pkg;

   localparam int DEFAULT_ENTRIES = 16;

   localparam logic [31:0] REACHABLE_TIMEOUT_RESET  = 32'd600000;
   localparam logic [31:0] INCOMPLETE_TIMEOUT_RESET = 32'd2000;

   localparam logic [7:0] REJECT_BYTE_LOW  = 8'h00;
   localparam logic [7:0] REJECT_BYTE_HIGH = 8'hFF;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [1:0] COND_INCOMPLETE = 2'd0;
   localparam logic [1:0] COND_REACHABLE  = 2'd1;
   localparam logic [1:0] COND_STALE      = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_REJECT     = 3'd1;
   localparam logic [2:0] ST_INCOMPLETE = 3'd2;
   localparam logic [2:0] ST_SOLICIT    = 3'd3;
   localparam logic [2:0] ST_NOROOM     = 3'd4;

   localparam logic REG_REACHABLE  = 1'b0;
   localparam logic REG_INCOMPLETE = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] ip_high;
      logic [63:0] ip_low;
      logic [47:0] link_addr;
      logic        unsolicited;
      logic        has_packet;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] link_out;
      logic        send_solicit;
      logic        release_pending;
   } rsp_type;

   typedef struct packed {
      logic [63:0] ip_high;
      logic [63:0] ip_low;
      logic [47:0] link;
      logic [47:0] stamp;
      logic [1:0]  cond;
      logic        pending;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/ipv6_neighbor_cache.sv */
// IPv6 neighbor cache: address table with aging, scanned one slot per cycle.
//
//   channel   direction  handshake                     payload
//   req       in         req_valid / req_ready         req_payload (ipnc_pkg::req_type)
//   rsp       out        rsp_valid / rsp_ready         rsp_payload (ipnc_pkg::rsp_type)
//   csr       in/out     csr_psel / csr_penable        csr_paddr, csr_pwdata, csr_prdata
//
// Each item scans every slot in turn: the entry memory is read once per
// slot through its single registered read port, and one compare unit checks each slot.
// A rejected insert skips the scan and goes straight to the decide step.
// Reset clears the valid flags, the timeouts go to their defaults; no clearing pass.
// A result waiting in the output register stalls only the final decide step.
`default_nettype none

module ipv6_neighbor_cache #(
   parameter int ENTRIES = ipnc_pkg::DEFAULT_ENTRIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ipnc_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ipnc_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import ipnc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic                 reject_ff, reject_in;
   logic [31:0]          reach_ff, reach_in;
   logic [31:0]          incomp_ff, incomp_in;
   logic [47:0]          lim_r_ff, lim_r_in;
   logic [47:0]          lim_i_ff, lim_i_in;
   logic                 lim_r_on_ff, lim_r_on_in;
   logic                 lim_i_on_ff, lim_i_on_in;
   logic [CNT_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic                 eval_on_ff, eval_on_in;
   logic [IDX_W-1:0]     eval_ptr_ff, eval_ptr_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [ENTRIES-1:0]   expire_ff, expire_in;
   logic                 hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [47:0]          hit_link_ff, hit_link_in;
   logic [1:0]           hit_cond_ff, hit_cond_in;
   logic                 hit_pend_ff, hit_pend_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   entry_type            mem [ENTRIES];
   entry_type            rd_data_ff;
   entry_type            wr_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;

   logic [48:0]          diff_r;
   logic [48:0]          diff_i;
   logic                 cur_valid;
   logic                 old_r;
   logic                 old_i;
   logic                 expired;
   logic                 ip_eq;
   logic                 hit_now;
   logic                 free_now;
   logic                 csr_write;
   logic                 go_decide;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == REG_INCOMPLETE) ? incomp_ff : reach_ff;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite;

   assign diff_r = {1'b0, req_payload.now_ms} - {17'd0, reach_ff};
   assign diff_i = {1'b0, req_payload.now_ms} - {17'd0, incomp_ff};

   assign cur_valid = valid_ff[eval_ptr_ff];
   assign old_r     = lim_r_on_ff && (rd_data_ff.stamp < lim_r_ff);
   assign old_i     = lim_i_on_ff && (rd_data_ff.cond == COND_INCOMPLETE) &&
                      (rd_data_ff.stamp < lim_i_ff);
   assign expired   = cur_valid && (old_r || old_i);
   assign ip_eq     = (rd_data_ff.ip_high == req_ff.ip_high) &&
                      (rd_data_ff.ip_low == req_ff.ip_low);
   assign hit_now   = cur_valid && ip_eq && ((req_ff.kind == KIND_INSERT) || !expired);
   assign free_now  = !cur_valid || expired;
   assign go_decide = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      reject_in     = reject_ff;
      reach_in      = reach_ff;
      incomp_in     = incomp_ff;
      lim_r_in      = lim_r_ff;
      lim_i_in      = lim_i_ff;
      lim_r_on_in   = lim_r_on_ff;
      lim_i_on_in   = lim_i_on_ff;
      scan_ptr_in   = scan_ptr_ff;
      eval_on_in    = 1'b0;
      eval_ptr_in   = eval_ptr_ff;
      valid_in      = valid_ff;
      expire_in     = expire_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_link_in   = hit_link_ff;
      hit_cond_in   = hit_cond_ff;
      hit_pend_in   = hit_pend_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_idx        = hit_idx_ff;
      wr_data       = '{ip_high: req_ff.ip_high, ip_low: req_ff.ip_low,
                        link: req_ff.link_addr, stamp: req_ff.now_ms,
                        cond: COND_REACHABLE, pending: 1'b0};

      if (csr_write && csr_pready) begin
         if (csr_paddr[2] == REG_INCOMPLETE) begin
            incomp_in = csr_pwdata;
         end else begin
            reach_in = csr_pwdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               reject_in     = (req_payload.kind == KIND_INSERT) &&
                               ((req_payload.ip_high[63:56] == REJECT_BYTE_LOW) ||
                                (req_payload.ip_high[63:56] == REJECT_BYTE_HIGH));
               lim_r_in      = diff_r[47:0];
               lim_i_in      = diff_i[47:0];
               lim_r_on_in   = !diff_r[48];
               lim_i_on_in   = !diff_i[48];
               scan_ptr_in   = '0;
               expire_in     = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = reject_in ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            scan_ptr_in = scan_ptr_ff + CNT_W'(1);
            eval_on_in  = (scan_ptr_ff != SCAN_END);
            eval_ptr_in = scan_ptr_ff[IDX_W-1:0];
            if (eval_on_ff) begin
               expire_in[eval_ptr_ff] = expired;
               if (hit_now && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = eval_ptr_ff;
                  hit_link_in  = rd_data_ff.link;
                  hit_cond_in  = rd_data_ff.cond;
                  hit_pend_in  = rd_data_ff.pending;
               end
               if (free_now && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = eval_ptr_ff;
               end
               if (eval_ptr_ff == LAST_IDX) begin
                  state_in   = S_DECIDE;
                  eval_on_in = 1'b0;
               end
            end
         end
         S_DECIDE: begin
            if (go_decide) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_OK, link_out: 48'd0,
                                send_solicit: 1'b0, release_pending: 1'b0};
               state_in     = S_IDLE;
               if (reject_ff) begin
                  rsp_in.status = ST_REJECT;
               end else if (req_ff.kind == KIND_INSERT) begin
                  if (hit_found_ff) begin
                     wr_en        = 1'b1;
                     wr_data.cond = (req_ff.unsolicited && (hit_link_ff != req_ff.link_addr)) ?
                                    COND_STALE : COND_REACHABLE;
                     rsp_in.release_pending = hit_pend_ff;
                  end else begin
                     valid_in = valid_ff & ~expire_ff;
                     if (free_found_ff) begin
                        wr_en            = 1'b1;
                        wr_idx           = free_idx_ff;
                        wr_data.cond     = req_ff.unsolicited ? COND_STALE : COND_REACHABLE;
                        valid_in[wr_idx] = 1'b1;
                     end else begin
                        rsp_in.status = ST_NOROOM;
                     end
                  end
               end else begin
                  valid_in = valid_ff & ~expire_ff;
                  if (hit_found_ff) begin
                     if (hit_cond_ff == COND_INCOMPLETE) begin
                        rsp_in.status = ST_INCOMPLETE;
                     end else begin
                        rsp_in.link_out     = hit_link_ff;
                        rsp_in.send_solicit = (hit_cond_ff == COND_STALE);
                     end
                  end else if (free_found_ff) begin
                     wr_en               = 1'b1;
                     wr_idx              = free_idx_ff;
                     wr_data.link        = 48'd0;
                     wr_data.cond        = COND_INCOMPLETE;
                     wr_data.pending     = req_ff.has_packet;
                     valid_in[wr_idx]    = 1'b1;
                     rsp_in.status       = ST_SOLICIT;
                     rsp_in.send_solicit = 1'b1;
                  end else begin
                     rsp_in.status = ST_NOROOM;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reach_ff     <= REACHABLE_TIMEOUT_RESET;
         incomp_ff    <= INCOMPLETE_TIMEOUT_RESET;
         valid_ff     <= '0;
         eval_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reach_ff     <= reach_in;
         incomp_ff    <= incomp_in;
         valid_ff     <= valid_in;
         eval_on_ff   <= eval_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      reject_ff     <= reject_in;
      lim_r_ff      <= lim_r_in;
      lim_i_ff      <= lim_i_in;
      lim_r_on_ff   <= lim_r_on_in;
      lim_i_on_ff   <= lim_i_on_in;
      scan_ptr_ff   <= scan_ptr_in;
      eval_ptr_ff   <= eval_ptr_in;
      expire_ff     <= expire_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_link_ff   <= hit_link_in;
      hit_cond_ff   <= hit_cond_in;
      hit_pend_ff   <= hit_pend_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[scan_ptr_ff[IDX_W-1:0]];
   end

`include "ipv6_neighbor_cache_assert.svh"

   `IPNC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `IPNC_ASSERT_IMPLIES(a_link_only_on_ok, rsp_valid && (rsp_payload.status != ST_OK), rsp_payload.link_out == 48'd0, "link address on failed transaction")
   `IPNC_ASSERT_IMPLIES(a_release_on_insert, rsp_valid && rsp_payload.release_pending, (rsp_payload.status == ST_OK) && !rsp_payload.send_solicit, "release with bad status")
   `IPNC_ASSERT_HOLDS(a_no_result_while_scanning, !((state_ff == S_SCAN) && $rose(rsp_valid_ff)), "result raised during scan")

endmodule

`default_nettype wire
